// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iirf4_pkg.sv =====
// ---------------------------------------------------------------------------
// iirf4_pkg
// Types, codes and constants shared by the fourth-order IIR filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package iirf4_pkg;

  localparam int SAMPLE_IN_W = 32;
  localparam int COEFF_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int FF_TAPS     = 5;
  localparam int FB_TAPS     = 4;
  localparam int HIST_DEPTH  = 4;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FF_0_1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_2_3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_4   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_1_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_3_4 = 3'd4;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  // input register state seen by the rest of the block
  typedef struct packed {
    logic valid;
    logic preset;
    logic clipped;
  } iirf4_ctl_t;

  // largest sample of a sw-bit range, as a full-width word
  function automatic logic [SAMPLE_IN_W-1:0] range_max(input int unsigned sw);
    logic [63:0] m;
    m = (64'd1 << (sw - 1)) - 64'd1;
    range_max = m[SAMPLE_IN_W-1:0];
  endfunction

endpackage

// ===== rtl/iirf4_in_reg.sv =====
// ---------------------------------------------------------------------------
// iirf4_in_reg
// Input register: takes a beat, clamps the sample to the sample range.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iirf4_in_reg import iirf4_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic signed [SAMPLE_IN_W-1:0]  in_sample_value,
  input  logic                           adv,
  output iirf4_ctl_t                     ctl,
  output logic signed [SAMPLE_WIDTH-1:0] x
);

  localparam logic signed [SAMPLE_IN_W-1:0] SMAX = $signed(range_max(SAMPLE_WIDTH));
  localparam logic signed [SAMPLE_IN_W-1:0] SMIN = ~SMAX;

  logic                           valid_r;
  logic                           valid_nxt;
  logic                           preset_r;
  logic                           clipped_r;
  logic                           clipped_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_IN_W-1:0]  x_nxt;
  logic                           load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    clipped_nxt = 1'b0;
    x_nxt       = in_sample_value;
    if (in_sample_value > SMAX) begin
      x_nxt       = SMAX;
      clipped_nxt = 1'b1;
    end else if (in_sample_value < SMIN) begin
      x_nxt       = SMIN;
      clipped_nxt = 1'b1;
    end
  end

  assign valid_nxt = load ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      preset_r  <= (in_operation == OP_PRESET);
      clipped_r <= clipped_nxt;
      x_r       <= x_nxt[SAMPLE_WIDTH-1:0];
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.preset  = preset_r;
  assign ctl.clipped = clipped_r;
  assign x           = x_r;

endmodule

// ===== rtl/iirf4_mac.sv =====
// ---------------------------------------------------------------------------
// iirf4_mac
// Nine parallel products, exact sum, round to sample format, saturate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iirf4_mac import iirf4_pkg::*; #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int COEFF_FRAC_BITS = 20
) (
  input  logic signed [SAMPLE_WIDTH-1:0] x0,
  input  logic signed [SAMPLE_WIDTH-1:0] x_hist [HIST_DEPTH],
  input  logic signed [SAMPLE_WIDTH-1:0] y_hist [HIST_DEPTH],
  input  coeff_t                         ff [FF_TAPS],
  input  coeff_t                         fb [FB_TAPS],
  output logic signed [SAMPLE_WIDTH-1:0] y,
  output logic                           clipped
);

  localparam int PROD_W = COEFF_W + SAMPLE_WIDTH;
  localparam int ACC_W  = PROD_W + 4;
  localparam int RES_W  = ACC_W - COEFF_FRAC_BITS;

  localparam logic [ACC_W-1:0] RND =
    {{(ACC_W-COEFF_FRAC_BITS){1'b0}}, 1'b1, {(COEFF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] YMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] YMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0] ff_prod [FF_TAPS];
  logic signed [PROD_W-1:0] fb_prod [FB_TAPS];
  logic signed [ACC_W-1:0]  acc;
  logic        [ACC_W-1:0]  acc_rnd;
  logic        [RES_W-1:0]  res;
  logic                     in_range;

  always_comb begin
    ff_prod[0] = ff[0] * x0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      ff_prod[i+1] = ff[i+1] * x_hist[i];
      fb_prod[i]   = fb[i] * y_hist[i];
    end
  end

  assign acc = ACC_W'(ff_prod[0]) + ACC_W'(ff_prod[1]) + ACC_W'(ff_prod[2])
             + ACC_W'(ff_prod[3]) + ACC_W'(ff_prod[4])
             - ACC_W'(fb_prod[0]) - ACC_W'(fb_prod[1])
             - ACC_W'(fb_prod[2]) - ACC_W'(fb_prod[3]);

  assign acc_rnd = acc + RND;
  assign res     = acc_rnd[ACC_W-1:COEFF_FRAC_BITS];

  // fits when every bit above the sample sign matches it
  assign in_range = (res[RES_W-1:SAMPLE_WIDTH-1] == '0) ||
                    (res[RES_W-1:SAMPLE_WIDTH-1] == '1);

  always_comb begin
    clipped = !in_range;
    if (in_range) begin
      y = $signed(res[SAMPLE_WIDTH-1:0]);
    end else if (res[RES_W-1]) begin
      y = YMIN;
    end else begin
      y = YMAX;
    end
  end

endmodule

// ===== rtl/iir_filter_order4.sv =====
// ---------------------------------------------------------------------------
// iir_filter_order4
// Fourth-order direct form I IIR filter, Q16.16 samples, Q12.20 coefficients.
// ---------------------------------------------------------------------------
// Input beat: in_operation (filter or preset) and in_sample_value, taken when
// in_valid is high and in_stall low. Result beat: out_filtered_value and
// out_saturated, taken when out_valid is high and out_stall low.
// Coefficients are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// the user must write them only while the filter is idle, the block does not
// enforce this. cfg_ready is always high, unknown indexes are dropped.
// A beat passes the input register, then the result register. Throughput: one
// beat per cycle while no result is held by out_stall; the nine products, sum,
// rounding and saturation sit combinationally between the input register and the
// result/history registers, since each output feeds the next sample.
// Reset clears coefficients, both histories and all valid flags.
// When out_stall holds a result, one more beat waits in the input register;
// in_stall rises only once that is full too.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iir_filter_order4 import iirf4_pkg::*; #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int COEFF_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_IN_W-1:0] in_sample_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_IN_W-1:0] out_filtered_value,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam logic signed [SAMPLE_IN_W-1:0] OUT_MAX = $signed(range_max(SAMPLE_WIDTH));
  localparam logic signed [SAMPLE_IN_W-1:0] OUT_MIN = ~OUT_MAX;

  iirf4_ctl_t                     ctl;
  logic signed [SAMPLE_WIDTH-1:0] s1_x;
  logic                           adv;

  coeff_t                         ff_r [FF_TAPS];
  coeff_t                         fb_r [FB_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] x_hist_r [HIST_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] y_hist_r [HIST_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] y_hist_nxt_head;
  logic signed [SAMPLE_WIDTH-1:0] mac_y;
  logic                           mac_clipped;

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_IN_W-1:0]  out_value_r;
  logic signed [SAMPLE_IN_W-1:0]  out_value_nxt;
  logic                           out_sat_r;
  logic                           out_sat_nxt;

  iirf4_in_reg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_sample_value(in_sample_value),
    .adv            (adv),
    .ctl            (ctl),
    .x              (s1_x)
  );

  iirf4_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_mac (
    .x0     (s1_x),
    .x_hist (x_hist_r),
    .y_hist (y_hist_r),
    .ff     (ff_r),
    .fb     (fb_r),
    .y      (mac_y),
    .clipped(mac_clipped)
  );

  assign adv       = ctl.valid && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FF_TAPS; i++) ff_r[i] <= '0;
      for (int i = 0; i < FB_TAPS; i++) fb_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FF_0_1: begin
          ff_r[0] <= cfg_data[31:0];
          ff_r[1] <= cfg_data[63:32];
        end
        CFG_FF_2_3: begin
          ff_r[2] <= cfg_data[31:0];
          ff_r[3] <= cfg_data[63:32];
        end
        CFG_FF_4: begin
          ff_r[4] <= cfg_data[31:0];
        end
        CFG_FB_1_2: begin
          fb_r[0] <= cfg_data[31:0];
          fb_r[1] <= cfg_data[63:32];
        end
        CFG_FB_3_4: begin
          fb_r[2] <= cfg_data[31:0];
          fb_r[3] <= cfg_data[63:32];
        end
        default: ;
      endcase
    end
  end

  assign y_hist_nxt_head = ctl.preset ? s1_x : mac_y;

  // histories: shift on a sample, fill on a preset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
    end else if (adv) begin
      if (ctl.preset) begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          x_hist_r[i] <= s1_x;
          y_hist_r[i] <= s1_x;
        end
      end else begin
        for (int i = 1; i < HIST_DEPTH; i++) begin
          x_hist_r[i] <= x_hist_r[i-1];
          y_hist_r[i] <= y_hist_r[i-1];
        end
        x_hist_r[0] <= s1_x;
        y_hist_r[0] <= y_hist_nxt_head;
      end
    end
  end

  // result register
  assign out_value_nxt = SAMPLE_IN_W'(y_hist_nxt_head);
  assign out_sat_nxt   = ctl.preset ? ctl.clipped : mac_clipped;
  assign out_valid_nxt = adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= out_value_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_saturated      = out_sat_r;

  `ASSERT_NEXT(a_adv_gives_result, clk, rst_n, adv, out_valid_r, "result beat lost")
  `ASSERT_IMPLIES(a_sat_on_rail, clk, rst_n, out_valid_r && out_sat_r, (out_value_r == OUT_MAX) || (out_value_r == OUT_MIN), "saturated result off the rails")
  `ASSERT_NEXT(a_in_reg_holds, clk, rst_n, ctl.valid && out_valid_r && out_stall, ctl.valid && $stable(s1_x), "waiting beat dropped")
  `ASSERT_NEXT(a_hist_shift, clk, rst_n, adv && !ctl.preset, (x_hist_r[1] == $past(x_hist_r[0])) && (y_hist_r[1] == $past(y_hist_r[0])), "history shift broken")

endmodule

// ===== test/iir_filter_order4_check.sv =====
// ----------------------------------------------------------------------------
// iir_filter_order4_check
// Watches the coefficient, sample and result channels of the fourth-order IIR
// filter. It keeps its own coefficients and histories and predicts every
// result beat. Each result is compared field by field with the oldest
// prediction. The mismatch count and the number of predictions still waiting
// go to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_filter_order4_check import iirf4_pkg::*; #(
  parameter int SAMPLE_WIDTH    = 32,
  parameter int COEFF_FRAC_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic signed [SAMPLE_IN_W-1:0] in_sample_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_IN_W-1:0] out_filtered_value,
  input  logic                          out_saturated,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   pending,
  output int unsigned                   clip_count
);

  localparam logic signed [127:0] RANGE_HI   = (128'sd1 <<< (SAMPLE_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] RANGE_LO   = -RANGE_HI - 128'sd1;
  localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (COEFF_FRAC_BITS - 1);

  logic [CFG_DATA_W-1:0] ff_0_1, ff_2_3, fb_1_2, fb_3_4;
  logic [COEFF_W-1:0]    ff_4;

  logic signed [SAMPLE_IN_W-1:0] x_hist [HIST_DEPTH];
  logic signed [SAMPLE_IN_W-1:0] y_hist [HIST_DEPTH];

  logic signed [SAMPLE_IN_W-1:0] want_value_q [$];
  logic                          want_sat_q [$];

  int unsigned errors  = 0;
  int unsigned clipped = 0;

  function automatic logic signed [127:0] product(input logic signed [COEFF_W-1:0] c,
                                                  input logic signed [SAMPLE_IN_W-1:0] v);
    logic signed [127:0] cw, vw;
    cw = c;
    vw = v;
    return cw * vw;
  endfunction

  task automatic predict_beat(input logic op, input logic signed [SAMPLE_IN_W-1:0] raw,
                              output logic signed [SAMPLE_IN_W-1:0] y, output logic clip);
    logic signed [127:0]         x_wide, acc, scaled;
    logic signed [SAMPLE_IN_W-1:0] x0;
    coeff_t                      b [FF_TAPS];
    coeff_t                      a [FB_TAPS];
    int                          i;
    x_wide = raw;
    clip = 1'b0;
    if (x_wide > RANGE_HI) begin
      x_wide = RANGE_HI;
      clip = 1'b1;
    end else if (x_wide < RANGE_LO) begin
      x_wide = RANGE_LO;
      clip = 1'b1;
    end
    x0 = x_wide[SAMPLE_IN_W-1:0];
    if (op == OP_PRESET) begin
      for (i = 0; i < HIST_DEPTH; i++) begin
        x_hist[i] = x0;
        y_hist[i] = x0;
      end
      y = x0;
    end else begin
      b[0] = ff_0_1[31:0];
      b[1] = ff_0_1[63:32];
      b[2] = ff_2_3[31:0];
      b[3] = ff_2_3[63:32];
      b[4] = ff_4;
      a[0] = fb_1_2[31:0];
      a[1] = fb_1_2[63:32];
      a[2] = fb_3_4[31:0];
      a[3] = fb_3_4[63:32];
      acc = product(b[0], x0) + ROUND_HALF;
      for (i = 0; i < HIST_DEPTH; i++)
        acc = acc + product(b[i+1], x_hist[i]) - product(a[i], y_hist[i]);
      scaled = acc >>> COEFF_FRAC_BITS;
      // input clamp alone never flags a filtered sample
      clip = 1'b0;
      if (scaled > RANGE_HI) begin
        y = RANGE_HI[SAMPLE_IN_W-1:0];
        clip = 1'b1;
      end else if (scaled < RANGE_LO) begin
        y = RANGE_LO[SAMPLE_IN_W-1:0];
        clip = 1'b1;
      end else begin
        y = scaled[SAMPLE_IN_W-1:0];
      end
      for (i = HIST_DEPTH - 1; i > 0; i--) begin
        x_hist[i] = x_hist[i-1];
        y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = x0;
      y_hist[0] = y;
    end
  endtask

  always @(posedge clk) begin : watch
    logic signed [SAMPLE_IN_W-1:0] y, want_value;
    logic                          clip, want_sat;
    int                            i;
    if (!rst_n) begin
      ff_0_1 = '0;
      ff_2_3 = '0;
      ff_4   = '0;
      fb_1_2 = '0;
      fb_3_4 = '0;
      for (i = 0; i < HIST_DEPTH; i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      want_value_q.delete();
      want_sat_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FF_0_1: ff_0_1 = cfg_data;
          CFG_FF_2_3: ff_2_3 = cfg_data;
          CFG_FF_4:   ff_4   = cfg_data[COEFF_W-1:0];
          CFG_FB_1_2: fb_1_2 = cfg_data;
          CFG_FB_3_4: fb_3_4 = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_beat(in_operation, in_sample_value, y, clip);
        want_value_q.push_back(y);
        want_sat_q.push_back(clip);
      end
      if (out_valid && !out_stall) begin
        if (want_value_q.size() == 0) begin
          $error("result beat with nothing predicted: filtered_value %0d saturated %0b",
                 out_filtered_value, out_saturated);
          errors++;
        end else begin
          want_value = want_value_q.pop_front();
          want_sat   = want_sat_q.pop_front();
          if (want_sat)
            clipped++;
          if (out_filtered_value !== want_value) begin
            $error("filtered_value expected %0d got %0d", want_value, out_filtered_value);
            errors++;
          end
          if (out_saturated !== want_sat) begin
            $error("saturated expected %0b got %0b", want_sat, out_saturated);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    pending    <= want_value_q.size();
    clip_count <= clipped;
  end

endmodule

// ===== test/iir_filter_order4_test.sv =====
// ----------------------------------------------------------------------------
// iir_filter_order4_test
// Stimulus and verdict for the fourth-order IIR filter. A short directed part
// covers rounding, sample extremes, presets, a pure delay and overflow in both
// directions; random phases then load fresh coefficient sets (stable, mild,
// full range and extreme) and stream filter and preset beats with random gaps
// and result stalls, including one long hold that backs the filter up. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_filter_order4_test;
  import iirf4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int MODE_STABLE  = 0;
  localparam int MODE_WILD    = 1;
  localparam int MODE_EXTREME = 2;
  localparam int MODE_MILD    = 3;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS   = 170;
  localparam int HOLD_CYCLES   = 90;
  localparam int PRESSURE_PHASE = 2;

  localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] UNITY = 32'sh0010_0000;
  localparam logic signed [31:0] HALF  = 32'sh0008_0000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_operation = OP_FILTER;
  logic signed [SAMPLE_IN_W-1:0] in_sample_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_IN_W-1:0] out_filtered_value;
  logic                          out_saturated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  int unsigned mismatches, pending, clip_count;
  int unsigned hold_request = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned filter_beats = 0;
  int unsigned preset_beats = 0;
  int unsigned coeff_sets = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  iir_filter_order4 uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filtered_value(out_filtered_value), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  iir_filter_order4_check check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filtered_value(out_filtered_value), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .clip_count(clip_count)
  );

  task automatic send_beat(input logic op, input logic signed [31:0] value,
                           input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_sample_value <= value;
    do @(posedge clk); while (in_stall);
    if (op == OP_PRESET)
      preset_beats++;
    else
      filter_beats++;
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coeffs(input logic [63:0] f01, input logic [63:0] f23,
                             input logic [31:0] f4, input logic [63:0] b12,
                             input logic [63:0] b34);
    cfg_beat(CFG_FF_0_1, f01);
    cfg_beat(CFG_FF_2_3, f23);
    cfg_beat(CFG_FF_4, {$urandom, f4});
    cfg_beat(CFG_FB_1_2, b12);
    cfg_beat(CFG_FB_3_4, b34);
    // unknown index, must be dropped
    cfg_beat(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    coeff_sets++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coeff(input int mode);
    case (mode)
      MODE_STABLE: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      MODE_WILD:   return $urandom;
      MODE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return UNITY;
        endcase
      end
      MODE_MILD:   return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      4: begin
        case ($urandom_range(0, 4))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom_range(0, 512) - 256;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    if (tx_calm || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin : receiver
    int unsigned n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
      end else if (rx_calm) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int p, k, mode;
    logic op;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients: filter beats give zero, a preset passes its sample
    send_beat(OP_FILTER, 32'sh1234_5678, pick_gap());
    send_beat(OP_PRESET, S_MAX, pick_gap());
    send_beat(OP_FILTER, S_MIN, pick_gap());
    drain();

    // b0 = 0.5: halves round toward +inf
    load_coeffs({32'h0, HALF}, '0, '0, '0, '0);
    send_beat(OP_FILTER, 32'sd1, pick_gap());
    send_beat(OP_FILTER, -32'sd1, pick_gap());
    send_beat(OP_FILTER, 32'sd3, pick_gap());
    send_beat(OP_FILTER, -32'sd3, pick_gap());
    send_beat(OP_FILTER, S_MAX, pick_gap());
    send_beat(OP_FILTER, S_MIN, pick_gap());
    send_beat(OP_FILTER, 32'sd0, pick_gap());
    drain();

    // b0 and -a1 at full scale: overflow both ways
    load_coeffs({32'h0, S_MAX}, '0, '0, {32'h0, S_MIN}, '0);
    send_beat(OP_PRESET, 32'sd0, pick_gap());
    send_beat(OP_FILTER, S_MAX, pick_gap());
    send_beat(OP_FILTER, S_MIN, pick_gap());
    send_beat(OP_FILTER, 32'sd1, pick_gap());
    send_beat(OP_FILTER, -32'sd1, pick_gap());
    send_beat(OP_PRESET, S_MIN, pick_gap());
    send_beat(OP_FILTER, 32'sd0, pick_gap());
    drain();

    // b4 = 1.0: four-sample delay line behind a preset
    load_coeffs('0, '0, UNITY, '0, '0);
    send_beat(OP_PRESET, 32'sd7, pick_gap());
    for (k = 1; k <= 5; k++)
      send_beat(OP_FILTER, k, pick_gap());
    drain();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      mode = p % 4;
      load_coeffs({pick_coeff(mode), pick_coeff(mode)}, {pick_coeff(mode), pick_coeff(mode)},
                  pick_coeff(mode), {pick_coeff(mode), pick_coeff(mode)},
                  {pick_coeff(mode), pick_coeff(mode)});
      tx_calm = (p % 3 == 1) || (p == PRESSURE_PHASE);
      rx_calm = (p % 3 == 2) && (p != PRESSURE_PHASE);
      if (p == PRESSURE_PHASE)
        hold_request = HOLD_CYCLES;
      for (k = 0; k < PHASE_BEATS; k++) begin
        op = ($urandom_range(0, 9) == 0) ? OP_PRESET : OP_FILTER;
        send_beat(op, pick_sample(), pick_gap());
      end
      drain();
    end

    $display("Covered %0d filter and %0d preset beats over %0d coefficient sets,",
             filter_beats, preset_beats, coeff_sets);
    $display("with %0d clipped results and a long result hold-off.", clip_count);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
